// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, types and codes of the phase fold accumulator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int MAX_BINS    = 256;
   localparam int MAX_VECTOR  = 1024;
   localparam int BIN_W       = $clog2(MAX_BINS);
   localparam int ELEM_W      = $clog2(MAX_VECTOR);
   localparam int ACC_ADDR_W  = BIN_W + ELEM_W;
   localparam int ACC_DEPTH   = MAX_BINS * MAX_VECTOR;

   localparam int ACC_W       = 32;
   localparam int HITS_W      = 32;
   localparam int PHASE_W     = 32;
   localparam int SAMPLE_W    = 8;
   localparam int VAL_W       = SAMPLE_W + 1;
   localparam int CMD_W       = 2;
   localparam int RD_BIN_W    = 8;
   localparam int RD_ELEM_W   = 10;

   localparam int BINS_CFG_W  = 9;
   localparam int LEN_CFG_W   = 11;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [BINS_CFG_W-1:0] BINS_RESET  = BINS_CFG_W'(256);
   localparam logic [LEN_CFG_W-1:0]  LEN_RESET   = LEN_CFG_W'(1024);

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_BINS   = 3'd0,
      REG_LEN    = 3'd1,
      REG_SIGNED = 3'd2,
      REG_START  = 3'd3,
      REG_STEP   = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      OP_ACC   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [BIN_W-1:0]        bin;
      logic [ELEM_W-1:0]       elem;
      logic [VAL_W-1:0]        value;
      logic                    hit;
   } op_type;

   typedef struct packed {
      logic [BINS_CFG_W-1:0]   bins_in_use;
      logic [LEN_CFG_W-1:0]    vector_length;
      logic                    signed_samples;
      logic [PHASE_W-1:0]      start_phase;
      logic [PHASE_W-1:0]      phase_step;
   } cfg_type;

   typedef struct packed {
      logic                    sweeping;
      logic                    sweep_done;
   } back_status_type;

endpackage

// ===== rtl/pfa_if.sv =====
// ----------------------------------------------------------------------------
// pfa_req_if / pfa_rsp_if
// Valid/ready channels for commands in and read results out.
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       cmd;
   logic [SAMPLE_W-1:0]    sample_byte;
   logic [RD_BIN_W-1:0]    read_bin;
   logic [RD_ELEM_W-1:0]   read_element;

   modport source (output valid, cmd, sample_byte, read_bin, read_element, input ready);
   modport sink   (input valid, cmd, sample_byte, read_bin, read_element, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [ACC_W-1:0] sum;
   logic [HITS_W-1:0]      hits;

   modport source (output valid, sum, hits, input ready);
   modport sink   (input valid, sum, hits, output ready);
endinterface

// ===== rtl/pfa_csr.sv =====
// ----------------------------------------------------------------------------
// pfa_csr
// APB register file holding the fold configuration.
// ----------------------------------------------------------------------------
module pfa_csr import pfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_BINS:   cfg_in.bins_in_use    = pwdata[BINS_CFG_W-1:0];
            REG_LEN:    cfg_in.vector_length  = pwdata[LEN_CFG_W-1:0];
            REG_SIGNED: cfg_in.signed_samples = pwdata[0];
            REG_START:  cfg_in.start_phase    = pwdata[PHASE_W-1:0];
            REG_STEP:   cfg_in.phase_step     = pwdata[PHASE_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BINS:   prdata = CSR_DATA_W'(cfg_ff.bins_in_use);
         REG_LEN:    prdata = CSR_DATA_W'(cfg_ff.vector_length);
         REG_SIGNED: prdata = CSR_DATA_W'(cfg_ff.signed_samples);
         REG_START:  prdata = CSR_DATA_W'(cfg_ff.start_phase);
         REG_STEP:   prdata = CSR_DATA_W'(cfg_ff.phase_step);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bins_in_use    <= BINS_RESET;
         cfg_ff.vector_length  <= LEN_RESET;
         cfg_ff.signed_samples <= 1'b1;
         cfg_ff.start_phase    <= '0;
         cfg_ff.phase_step     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/pfa_front.sv =====
// ----------------------------------------------------------------------------
// pfa_front
// Command intake: spectrum framing, phase tracking and bin selection.
// ----------------------------------------------------------------------------
module pfa_front import pfa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   pfa_req_if.sink         req,
   input  cfg_type         cfg,
   input  back_status_type status,
   input  logic            q_full,
   output logic            push,
   output op_type          push_op
);

   logic [PHASE_W-1:0]            phase_ff,   phase_in;
   logic [ELEM_W-1:0]             elem_ff,    elem_in;
   logic [BIN_W-1:0]              bin_ff,     bin_in;
   logic                          nz_ff,      nz_in;
   logic                          clr_wait_ff, clr_wait_in;

   logic [BINS_CFG_W-1:0]         eff_bins;
   logic [LEN_CFG_W-1:0]          eff_len;
   logic [PHASE_W+BINS_CFG_W-1:0] prod;
   logic [BIN_W-1:0]              cur_bin;
   logic                          first;
   logic                          nz_cur;
   logic                          last;
   logic                          accept;
   logic [VAL_W-1:0]              value;

   always_comb begin
      if (cfg.bins_in_use == '0) begin
         eff_bins = BINS_CFG_W'(1);
      end else if (cfg.bins_in_use > BINS_CFG_W'(MAX_BINS)) begin
         eff_bins = BINS_CFG_W'(MAX_BINS);
      end else begin
         eff_bins = cfg.bins_in_use;
      end
      if (cfg.vector_length == '0) begin
         eff_len = LEN_CFG_W'(1);
      end else if (cfg.vector_length > LEN_CFG_W'(MAX_VECTOR)) begin
         eff_len = LEN_CFG_W'(MAX_VECTOR);
      end else begin
         eff_len = cfg.vector_length;
      end
   end

   assign prod    = {{BINS_CFG_W{1'b0}}, phase_ff} * {{PHASE_W{1'b0}}, eff_bins};
   assign first   = (elem_ff == '0);
   assign cur_bin = first ? prod[PHASE_W +: BIN_W] : bin_ff;
   assign nz_cur  = (first ? 1'b0 : nz_ff) | (|req.sample_byte);
   assign last    = (LEN_CFG_W'(elem_ff) + LEN_CFG_W'(1)) >= eff_len;
   assign value   = {cfg.signed_samples & req.sample_byte[SAMPLE_W-1], req.sample_byte};

   assign req.ready = !q_full && !clr_wait_ff && !status.sweeping;
   assign accept    = req.valid && req.ready;

   always_comb begin
      phase_in    = phase_ff;
      elem_in     = elem_ff;
      bin_in      = bin_ff;
      nz_in       = nz_ff;
      clr_wait_in = clr_wait_ff;
      push        = 1'b0;
      push_op     = '{kind: OP_ACC, bin: cur_bin, elem: elem_ff, value: value,
                      hit: last && nz_cur};
      if (status.sweep_done) begin
         clr_wait_in = 1'b0;
      end
      if (accept) begin
         unique case (cmd_type'(req.cmd))
            CMD_SAMPLE: begin
               push   = 1'b1;
               bin_in = cur_bin;
               if (last) begin
                  phase_in = phase_ff + cfg.phase_step;
                  elem_in  = '0;
                  nz_in    = 1'b0;
               end else begin
                  elem_in  = elem_ff + ELEM_W'(1);
                  nz_in    = nz_cur;
               end
            end
            CMD_LOAD: begin
               phase_in = cfg.start_phase;
               elem_in  = '0;
               nz_in    = 1'b0;
            end
            CMD_CLEAR: begin
               push         = 1'b1;
               push_op.kind = OP_CLEAR;
               elem_in      = '0;
               nz_in        = 1'b0;
               clr_wait_in  = 1'b1;
            end
            CMD_READ: begin
               push         = 1'b1;
               push_op.kind = OP_READ;
               push_op.bin  = req.read_bin[BIN_W-1:0];
               push_op.elem = req.read_element[ELEM_W-1:0];
            end
            default: push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         elem_ff     <= '0;
         bin_ff      <= '0;
         nz_ff       <= 1'b0;
         clr_wait_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         elem_ff     <= elem_in;
         bin_ff      <= bin_in;
         nz_ff       <= nz_in;
         clr_wait_ff <= clr_wait_in;
      end
   end

endmodule

// ===== rtl/pfa_queue.sv =====
// ----------------------------------------------------------------------------
// pfa_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module pfa_queue import pfa_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   op_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/pfa_back.sv =====
// ----------------------------------------------------------------------------
// pfa_back
// Accumulator and hit-count memories: read-modify-write with forwarding,
// readout register and clearing sweep.
// ----------------------------------------------------------------------------
module pfa_back import pfa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  op_type          head_op,
   output logic            pop,
   output back_status_type status,
   pfa_rsp_if.source       rsp
);

   typedef enum logic {ST_SWEEP, ST_RUN} state_type;

   logic [ACC_W-1:0]      acc_mem  [ACC_DEPTH];
   logic [HITS_W-1:0]     hits_mem [MAX_BINS];

   state_type             state_ff,    state_in;
   logic [ACC_ADDR_W-1:0] sweep_ff,    sweep_in;
   logic                  s1_valid_ff, s1_valid_in;
   op_type                s1_op_ff,    s1_op_in;
   logic                  fa_valid_ff, fa_valid_in;
   logic [ACC_ADDR_W-1:0] fa_addr_ff,  fa_addr_in;
   logic [ACC_W-1:0]      fa_data_ff,  fa_data_in;
   logic                  fh_valid_ff, fh_valid_in;
   logic [BIN_W-1:0]      fh_addr_ff,  fh_addr_in;
   logic [HITS_W-1:0]     fh_data_ff,  fh_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]      sum_ff,      sum_in;
   logic [HITS_W-1:0]     hits_ff,     hits_in;
   logic [ACC_W-1:0]      acc_rd_ff;
   logic [HITS_W-1:0]     hits_rd_ff;

   logic [ACC_ADDR_W-1:0] head_addr;
   logic [ACC_ADDR_W-1:0] s1_addr;
   logic [ACC_W-1:0]      acc_cur;
   logic [HITS_W-1:0]     hits_cur;
   logic [ACC_W:0]        sum_wide;
   logic [ACC_W-1:0]      acc_new;
   logic [HITS_W-1:0]     hits_new;
   logic                  s1_go;
   logic                  s1_acc;
   logic                  acc_we;
   logic [ACC_ADDR_W-1:0] acc_waddr;
   logic [ACC_W-1:0]      acc_wdata;
   logic                  hits_we;
   logic [BIN_W-1:0]      hits_waddr;
   logic [HITS_W-1:0]     hits_wdata;
   logic                  sweep_last;

   assign head_addr  = {head_op.bin, head_op.elem};
   assign s1_addr    = {s1_op_ff.bin, s1_op_ff.elem};
   assign sweep_last = (sweep_ff == '1);

   assign acc_cur  = (fa_valid_ff && fa_addr_ff == s1_addr) ? fa_data_ff : acc_rd_ff;
   assign hits_cur = (fh_valid_ff && fh_addr_ff == s1_op_ff.bin) ? fh_data_ff : hits_rd_ff;
   assign sum_wide = {acc_cur[ACC_W-1], acc_cur}
                   + {{(ACC_W+1-VAL_W){s1_op_ff.value[VAL_W-1]}}, s1_op_ff.value};

   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         acc_new = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_new = sum_wide[ACC_W-1:0];
      end
      hits_new = (hits_cur == '1) ? hits_cur : hits_cur + HITS_W'(1);
   end

   assign s1_go  = !s1_valid_ff || (s1_op_ff.kind != OP_READ) || !rsp_valid_ff || rsp.ready;
   assign s1_acc = s1_valid_ff && (s1_op_ff.kind == OP_ACC);
   assign pop    = (state_ff == ST_RUN) && head_valid && s1_go;

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         acc_we     = 1'b1;
         acc_waddr  = sweep_ff;
         acc_wdata  = '0;
         hits_we    = 1'b1;
         hits_waddr = sweep_ff[BIN_W-1:0];
         hits_wdata = '0;
      end else begin
         acc_we     = s1_acc;
         acc_waddr  = s1_addr;
         acc_wdata  = acc_new;
         hits_we    = s1_acc && s1_op_ff.hit;
         hits_waddr = s1_op_ff.bin;
         hits_wdata = hits_new;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      if (pop) begin
         acc_rd_ff <= acc_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (hits_we) begin
         hits_mem[hits_waddr] <= hits_wdata;
      end
      if (pop) begin
         hits_rd_ff <= hits_mem[head_op.bin];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      s1_valid_in  = s1_valid_ff;
      s1_op_in     = s1_op_ff;
      fa_valid_in  = fa_valid_ff;
      fa_addr_in   = fa_addr_ff;
      fa_data_in   = fa_data_ff;
      fh_valid_in  = fh_valid_ff;
      fh_addr_in   = fh_addr_ff;
      fh_data_in   = fh_data_ff;
      rsp_valid_in = rsp_valid_ff;
      sum_in       = sum_ff;
      hits_in      = hits_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SWEEP: begin
            sweep_in    = sweep_ff + ACC_ADDR_W'(1);
            fa_valid_in = 1'b0;
            fh_valid_in = 1'b0;
            if (sweep_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (s1_acc) begin
               fa_valid_in = 1'b1;
               fa_addr_in  = s1_addr;
               fa_data_in  = acc_new;
               if (s1_op_ff.hit) begin
                  fh_valid_in = 1'b1;
                  fh_addr_in  = s1_op_ff.bin;
                  fh_data_in  = hits_new;
               end
            end
            if (s1_valid_ff && s1_op_ff.kind == OP_READ && s1_go) begin
               rsp_valid_in = 1'b1;
               sum_in       = acc_cur;
               hits_in      = hits_cur;
            end
            if (s1_go) begin
               s1_valid_in = pop && (head_op.kind != OP_CLEAR);
               s1_op_in    = head_op;
            end
            if (pop && head_op.kind == OP_CLEAR) begin
               state_in = ST_SWEEP;
               sweep_in = '0;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         fa_valid_ff  <= 1'b0;
         fh_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         s1_valid_ff  <= s1_valid_in;
         fa_valid_ff  <= fa_valid_in;
         fh_valid_ff  <= fh_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_op_ff   <= s1_op_in;
      fa_addr_ff <= fa_addr_in;
      fa_data_ff <= fa_data_in;
      fh_addr_ff <= fh_addr_in;
      fh_data_ff <= fh_data_in;
      sum_ff     <= sum_in;
      hits_ff    <= hits_in;
   end

   assign status.sweeping   = (state_ff == ST_SWEEP);
   assign status.sweep_done = (state_ff == ST_SWEEP) && sweep_last;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.sum   = sum_ff;
   assign rsp.hits  = hits_ff;

endmodule

// ===== rtl/phase_fold_accumulator.sv =====
// ----------------------------------------------------------------------------
// phase_fold_accumulator
// Folds a stream of 8-bit spectra into phase bins with saturating sums
// and per-bin hit counts.
//
//   channel   direction  transfer carries
//   req_if    in         cmd, sample_byte, read_bin, read_element
//   rsp_if    out        sum, hits (one per read command)
//   APB       in/out     bins_in_use, vector_length, signed_samples,
//                        start_phase, phase_step
//
// One command a cycle unless stalled: each sample byte is one read-modify-write
// of the accumulator memory, with the last write forwarded to the next access.
// A read result sits in an output register; while it is held, one more read
// stalls the back end and the four-entry queue fills.
// After reset and after every clear command a clearing pass runs over all
// 262144 accumulator addresses; no command is taken until it ends.
// ----------------------------------------------------------------------------
module phase_fold_accumulator import pfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pfa_req_if.sink               req_if,
   pfa_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg;
   back_status_type status;
   logic            push;
   op_type          push_op;
   logic            q_full;
   logic            pop;
   logic            head_valid;
   op_type          head_op;

   pfa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pfa_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .cfg     (cfg),
      .status  (status),
      .q_full  (q_full),
      .push    (push),
      .push_op (push_op)
   );

   pfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   pfa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .status     (status),
      .rsp        (rsp_if)
   );

endmodule
